// ----- design/ptss_pkg.sv -----
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types and codes for the periodic tick slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_REGISTER = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    localparam int TICK_W  = 32;
    localparam int MASK_W  = 8;
    localparam int SLOTF_W = 3;

    typedef struct packed {
        logic [1:0]        action;
        logic [TICK_W-1:0] period_ticks;
    } req_t;

    typedef struct packed {
        logic [MASK_W-1:0]  fire_mask;
        logic [TICK_W-1:0]  tick_count;
        logic [SLOTF_W-1:0] slot_written;
    } rsp_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_status_t;

endpackage

// ----- design/ptss_slot_mem.sv -----
// ----------------------------------------------------------------------------
// ptss_slot_mem
// Slot period memory with one write port and a registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module ptss_slot_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [ptss_pkg::TICK_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [ptss_pkg::TICK_W-1:0] rd_data
);

    logic [ptss_pkg::TICK_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [ptss_pkg::TICK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/ptss_rem_unit.sv -----
// ----------------------------------------------------------------------------
// ptss_rem_unit
// Iterative restoring remainder unit, one dividend bit per cycle.
// Reports whether the divisor divides the dividend exactly.
// ----------------------------------------------------------------------------
module ptss_rem_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ptss_pkg::TICK_W-1:0] dividend,
    input  logic [ptss_pkg::TICK_W-1:0] divisor,
    output ptss_pkg::rem_status_t       status
);

    localparam int CNT_W = $clog2(ptss_pkg::TICK_W);

    logic                        busy_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [ptss_pkg::TICK_W:0]   rem_reg;
    logic [ptss_pkg::TICK_W-1:0] dvd_reg;
    logic [ptss_pkg::TICK_W-1:0] dsr_reg;
    logic                        done_reg;
    logic [ptss_pkg::TICK_W:0]   rem_shift;
    logic [ptss_pkg::TICK_W:0]   rem_next;

    always_comb
    begin
        rem_shift = {rem_reg[ptss_pkg::TICK_W-1:0], dvd_reg[ptss_pkg::TICK_W-1]};
        if (rem_shift >= {1'b0, dsr_reg})
        begin
            rem_next = rem_shift - {1'b0, dsr_reg};
        end
        else
        begin
            rem_next = rem_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ptss_pkg::TICK_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[ptss_pkg::TICK_W-2:0], 1'b0};
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

// ----- design/periodic_tick_slot_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_tick_slot_scheduler
// Tick counter with a table of slot periods held in a small memory. A tick
// reads each slot in turn and tests divisibility with an iterative remainder.
// ----------------------------------------------------------------------------
// Register, clear and unused items go through FINISH to the output register;
// a tick goes through READ and, for each of the first eight slots with a
// nonzero period, DIV in the one-bit-per-cycle remainder unit, skipping
// inactive slots, then FINISH. One item is in work at a time, so none is taken
// until the last is through; the next is taken while a result waits.
// Reset clears the counter, the ring index and the valid bits of all slots.
module periodic_tick_slot_scheduler #(
    parameter int SLOT_COUNT = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  ptss_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ptss_pkg::rsp_t   rsp
);

    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FIRE_SLOTS = (SLOT_COUNT < ptss_pkg::MASK_W) ? SLOT_COUNT
                                                                : ptss_pkg::MASK_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [ptss_pkg::TICK_W-1:0] ticks_reg;
    logic [ptss_pkg::TICK_W-1:0] ticks_next;
    logic [SLOT_W-1:0]           ring_reg;
    logic [SLOT_W-1:0]           ring_next;
    logic [SLOT_W-1:0]           slot_reg;
    logic [SLOT_W-1:0]           slot_next;
    logic [ptss_pkg::MASK_W-1:0] mask_reg;
    logic [ptss_pkg::MASK_W-1:0] mask_next;
    logic [1:0]                  act_reg;
    logic [1:0]                  act_next;
    logic                        rsp_valid_reg;
    ptss_pkg::rsp_t              rsp_reg;
    logic                        req_xfer;
    logic                        out_free;
    logic                        last_slot;
    logic                        div_start;
    logic                        mem_wr;
    logic [SLOT_W-1:0]           ring_inc;
    logic [ptss_pkg::TICK_W-1:0] period_rd;
    logic [SLOT_W+2:0]           ring_wide;
    ptss_pkg::rem_status_t       div_stat;

    ptss_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr),
        .wr_addr (ring_inc),
        .wr_data (req.period_ticks),
        .rd_addr (slot_next),
        .rd_data (period_rd)
    );

    ptss_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ticks_reg),
        .divisor  (period_rd),
        .status   (div_stat)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign last_slot = (slot_reg == SLOT_W'(FIRE_SLOTS - 1));
    assign ring_inc  = (ring_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : ring_reg + 1'b1;
    assign mem_wr    = req_xfer && (req.action == ptss_pkg::ACT_REGISTER);
    assign div_start = (state_reg == ST_READ) && (period_rd != '0);
    assign ring_wide = {3'b000, ring_reg};

    always_comb
    begin
        state_next = state_reg;
        ticks_next = ticks_reg;
        ring_next  = ring_reg;
        slot_next  = slot_reg;
        mask_next  = mask_reg;
        act_next   = act_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    act_next  = req.action;
                    mask_next = '0;
                    slot_next = '0;
                    case (req.action)
                        ptss_pkg::ACT_TICK:
                        begin
                            ticks_next = ticks_reg + 1'b1;
                            state_next = ST_READ;
                        end
                        ptss_pkg::ACT_REGISTER:
                        begin
                            ring_next  = ring_inc;
                            state_next = ST_FINISH;
                        end
                        ptss_pkg::ACT_CLEAR:
                        begin
                            ticks_next = '0;
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (period_rd != '0)
                begin
                    state_next = ST_DIV;
                end
                else if (last_slot)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.rem_zero)
                    begin
                        mask_next = mask_reg | (ptss_pkg::MASK_W'(1) << slot_reg);
                    end
                    if (last_slot)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ticks_reg     <= '0;
            ring_reg      <= '0;
            slot_reg      <= '0;
            mask_reg      <= '0;
            act_reg       <= ptss_pkg::ACT_TICK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ticks_reg <= ticks_next;
            ring_reg  <= ring_next;
            slot_reg  <= slot_next;
            mask_reg  <= mask_next;
            act_reg   <= act_next;
            if ((state_reg == ST_FINISH) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            rsp_reg.fire_mask    <= mask_reg;
            rsp_reg.tick_count   <= ticks_reg;
            rsp_reg.slot_written <= ring_wide[2:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg != ST_IDLE))
        else $error("Accepted transfer did not start processing.");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("Remainder unit finished outside the divide state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("Result appeared without a finished item.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && (act_reg != ptss_pkg::ACT_TICK)) |->
        (mask_reg == '0))
        else $error("Fire bits set for a non-tick item.");
`endif

endmodule
